@@ sv/rspm_pkg.sv @@
// Shared types and constants for the RC signal presence mux.
// Used by rspm_chan and rc_signal_presence_mux; depends on nothing.
`default_nettype none

package rspm_pkg;

    localparam int CFG_BITS  = 16;
    localparam int LOCK_BITS = 3;
    localparam int IDX_BITS  = 3;

    typedef enum logic [IDX_BITS-1:0] {
        REG_MIN_PERIOD    = 3'd0,
        REG_MAX_PERIOD    = 3'd1,
        REG_MIN_HIGH      = 3'd2,
        REG_MAX_HIGH      = 3'd3,
        REG_LOSS_TIMEOUT  = 3'd4,
        REG_SWITCH_THRESH = 3'd5,
        REG_PULSES_NEEDED = 3'd6
    } reg_idx_t;

    localparam logic [CFG_BITS-1:0]  RST_MIN_PERIOD    = 16'd50;
    localparam logic [CFG_BITS-1:0]  RST_MAX_PERIOD    = 16'd500;
    localparam logic [CFG_BITS-1:0]  RST_MIN_HIGH      = 16'd3;
    localparam logic [CFG_BITS-1:0]  RST_MAX_HIGH      = 16'd30;
    localparam logic [CFG_BITS-1:0]  RST_LOSS_TIMEOUT  = 16'd600;
    localparam logic [CFG_BITS-1:0]  RST_SWITCH_THRESH = 16'd15;
    localparam logic [LOCK_BITS-1:0] RST_PULSES_NEEDED = 3'd3;
    localparam logic [LOCK_BITS-1:0] RST_LOCK          = 3'd3;

    // Pulse windows, timeout and lock count shared by both channels.
    typedef struct packed {
        logic [CFG_BITS-1:0]  min_period;
        logic [CFG_BITS-1:0]  max_period;
        logic [CFG_BITS-1:0]  min_high;
        logic [CFG_BITS-1:0]  max_high;
        logic [CFG_BITS-1:0]  loss_timeout;
        logic [LOCK_BITS-1:0] pulses_needed;
    } chan_cfg_t;

endpackage

`default_nettype wire

@@ sv/rspm_chan.sv @@
// One RC channel tracker: high/low tick counters, pulse window check and lock counter.
// Depends on rspm_pkg.
`default_nettype none

module rspm_chan
    import rspm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  tick,
    input  wire logic                  level,
    input  wire chan_cfg_t             cfg,
    output logic                       present_next,
    output logic                       falling,
    output logic [COUNT_BITS-1:0]      high_count
);

    // Compare width covers the period sum and the 16-bit settings with room to zero-extend.
    localparam int WB = ((COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS) + 2;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                  prev_reg, prev_next;
    logic [COUNT_BITS-1:0] high_reg, high_next;
    logic [COUNT_BITS-1:0] low_reg, low_next;
    logic [LOCK_BITS-1:0]  lock_reg, lock_next;

    logic                  rising;
    logic                  pulse_ok;
    logic [COUNT_BITS:0]   period;
    logic [WB-1:0]         period_w, high_w, low_w;
    logic [WB-1:0]         min_period_w, max_period_w, min_high_w, max_high_w, timeout_w;
    logic [COUNT_BITS-1:0] high_clr, low_clr;
    logic [LOCK_BITS-1:0]  lock_dec;

    always_comb begin
        rising       = level & ~prev_reg;
        falling      = ~level & prev_reg;
        period       = {1'b0, high_reg} + {1'b0, low_reg};
        period_w     = {{(WB-COUNT_BITS-1){1'b0}}, period};
        high_w       = {{(WB-COUNT_BITS){1'b0}}, high_reg};
        min_period_w = {{(WB-CFG_BITS){1'b0}}, cfg.min_period};
        max_period_w = {{(WB-CFG_BITS){1'b0}}, cfg.max_period};
        min_high_w   = {{(WB-CFG_BITS){1'b0}}, cfg.min_high};
        max_high_w   = {{(WB-CFG_BITS){1'b0}}, cfg.max_high};
        timeout_w    = {{(WB-CFG_BITS){1'b0}}, cfg.loss_timeout};

        pulse_ok = (lock_reg != '0) && (period_w > min_period_w) && (period_w < max_period_w)
                && (high_w > min_high_w) && (high_w < max_high_w);

        // Edge handling uses the counts of the previous ticks.
        lock_dec = (rising && pulse_ok) ? lock_reg - 1'b1 : lock_reg;
        high_clr = rising ? '0 : high_reg;
        low_clr  = rising ? '0 : low_reg;

        lock_next = lock_dec;
        high_next = high_clr;
        low_next  = low_clr;
        low_w     = '0;
        if (!level) begin
            low_next = (low_clr == CNT_MAX) ? low_clr : low_clr + 1'b1;
            low_w    = {{(WB-COUNT_BITS){1'b0}}, low_next};
            // Signal lost: reload the lock and drop both counts.
            if (low_w > timeout_w) begin
                lock_next = cfg.pulses_needed;
                high_next = '0;
                low_next  = '0;
            end
        end else begin
            high_next = (high_clr == CNT_MAX) ? high_clr : high_clr + 1'b1;
        end
        prev_next = level;

        present_next = (lock_next == '0);
        high_count   = high_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= 1'b0;
            high_reg <= '0;
            low_reg  <= '0;
            lock_reg <= RST_LOCK;
        end else if (tick) begin
            prev_reg <= prev_next;
            high_reg <= high_next;
            low_reg  <= low_next;
            lock_reg <= lock_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/rc_signal_presence_mux.sv @@
// Top level of the RC signal presence mux: config registers, two channel trackers,
// drive select and the result register. Depends on rspm_pkg and rspm_chan.
`default_nettype none

// Takes one sampled 100us tick per word on the s_ side and returns one status word
// per tick on the m_ side. A tick is accepted in every cycle while the result
// register is empty or being drained; its result appears in the next cycle, set by
// the single result register behind the per-channel counter and compare logic.
// The status reflects both channels after the tick: a channel is present once good
// pulses bring its lock counter to zero (it reloads with pulses_needed on loss), and
// rc_drive follows the latched switch high time while the switch is present, else the
// primary presence. Write the config registers only while no word is in flight.
module rc_signal_presence_mux
    import rspm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] primary_level, [1] switch_level
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [0] rc_drive, [1] primary_present,
                                                 // [2] switch_present
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_BITS-1:0]  cfg_data
);

    localparam int WB = ((COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS) + 1;

    chan_cfg_t             chan_cfg_reg;
    logic [CFG_BITS-1:0]   switch_thresh_reg;
    logic [COUNT_BITS-1:0] last_high_reg, last_high_next;
    logic                  m_tvalid_reg;
    logic [2:0]            result_reg, result_next;

    logic                  tick;
    logic                  p_present, s_present, p_falling, s_falling;
    logic [COUNT_BITS-1:0] p_high, s_high;
    logic [WB-1:0]         last_high_w, thresh_w;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_tvalid_reg | m_tready;
    assign tick      = s_tvalid & s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'b0, result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_cfg_reg.min_period    <= RST_MIN_PERIOD;
            chan_cfg_reg.max_period    <= RST_MAX_PERIOD;
            chan_cfg_reg.min_high      <= RST_MIN_HIGH;
            chan_cfg_reg.max_high      <= RST_MAX_HIGH;
            chan_cfg_reg.loss_timeout  <= RST_LOSS_TIMEOUT;
            chan_cfg_reg.pulses_needed <= RST_PULSES_NEEDED;
            switch_thresh_reg          <= RST_SWITCH_THRESH;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_PERIOD:    chan_cfg_reg.min_period    <= cfg_data;
                REG_MAX_PERIOD:    chan_cfg_reg.max_period    <= cfg_data;
                REG_MIN_HIGH:      chan_cfg_reg.min_high      <= cfg_data;
                REG_MAX_HIGH:      chan_cfg_reg.max_high      <= cfg_data;
                REG_LOSS_TIMEOUT:  chan_cfg_reg.loss_timeout  <= cfg_data;
                REG_SWITCH_THRESH: switch_thresh_reg          <= cfg_data;
                REG_PULSES_NEEDED: chan_cfg_reg.pulses_needed <= cfg_data[LOCK_BITS-1:0];
                default: ;
            endcase
        end
    end

    rspm_chan #(.COUNT_BITS(COUNT_BITS)) u_primary (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (tick),
        .level        (s_tdata[0]),
        .cfg          (chan_cfg_reg),
        .present_next (p_present),
        .falling      (p_falling),
        .high_count   (p_high)
    );

    rspm_chan #(.COUNT_BITS(COUNT_BITS)) u_switch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (tick),
        .level        (s_tdata[1]),
        .cfg          (chan_cfg_reg),
        .present_next (s_present),
        .falling      (s_falling),
        .high_count   (s_high)
    );

    always_comb begin
        // Latch the switch high time on its falling edge.
        last_high_next = s_falling ? s_high : last_high_reg;
        last_high_w    = {{(WB-COUNT_BITS){1'b0}}, last_high_next};
        thresh_w       = {{(WB-CFG_BITS){1'b0}}, switch_thresh_reg};
        result_next[1] = p_present;
        result_next[2] = s_present;
        result_next[0] = s_present ? (last_high_w > thresh_w) : p_present;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg  <= 1'b0;
            last_high_reg <= '0;
        end else begin
            if (tick) begin
                m_tvalid_reg  <= 1'b1;
                last_high_reg <= last_high_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result is stalled");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted tick produced no result");

    a_drive_follows_primary: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[0] == m_tdata[1]))
        else $error("rc_drive differs from primary presence without switch");
`endif

endmodule

`default_nettype wire

@@ sim/rspm_status_check.sv @@
`timescale 1ns / 1ps
// Status checker for the RC signal presence mux: tracks config writes and input ticks,
// predicts each status word and compares it with the m_ side. Depends on rspm_pkg.
module rspm_status_check
    import rspm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,   // [0] primary_level, [1] switch_level
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [7:0]          m_tdata,   // [0] rc_drive, [1] primary_present,
                                           // [2] switch_present
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    output int                  fail_count,
    output int                  owed
);

    localparam int CNT_BITS = 16;

    typedef struct {
        bit                 prev;
        bit [CNT_BITS-1:0]  hi;
        bit [CNT_BITS-1:0]  lo;
        bit [LOCK_BITS-1:0] lock;
    } chan_track_t;

    typedef struct packed {
        bit switch_present;
        bit primary_present;
        bit rc_drive;
    } status_t;

    chan_cfg_t           win;
    logic [CFG_BITS-1:0] threshold;
    chan_track_t         prim;
    chan_track_t         swch;
    bit [CNT_BITS-1:0]   last_switch_high;
    status_t             status_due[$];

    initial fail_count = 0;
    initial owed = 0;

    // Advance one channel by one tick; returns 1 on a falling edge.
    function automatic bit track_channel(inout chan_track_t c, input bit level);
        bit [CNT_BITS:0] period;
        bit              fell;
        fell = 1'b0;
        if (level && !c.prev) begin
            period = {1'b0, c.hi} + {1'b0, c.lo};
            if (c.lock != 0 && period > win.min_period && period < win.max_period &&
                c.hi > win.min_high && c.hi < win.max_high) begin
                c.lock = c.lock - 1'b1;
            end
            c.hi = '0;
            c.lo = '0;
        end
        if (!level && c.prev)
            fell = 1'b1;
        if (!level) begin
            if (c.lo != '1)
                c.lo = c.lo + 1'b1;
            // lost: reload the lock and drop both counts
            if (c.lo > win.loss_timeout) begin
                c.lock = win.pulses_needed;
                c.hi = '0;
                c.lo = '0;
            end
        end else if (c.hi != '1) begin
            c.hi = c.hi + 1'b1;
        end
        c.prev = level;
        return fell;
    endfunction

    function automatic status_t predict_status(bit p_level, bit s_level);
        bit [CNT_BITS-1:0] sw_hi_before;
        status_t           st;
        sw_hi_before = swch.hi;
        void'(track_channel(prim, p_level));
        if (track_channel(swch, s_level))
            last_switch_high = sw_hi_before;
        st.primary_present = (prim.lock == 0);
        st.switch_present  = (swch.lock == 0);
        st.rc_drive = st.switch_present ? (last_switch_high > threshold) : st.primary_present;
        return st;
    endfunction

    always @(posedge aclk) begin : watch
        status_t got;
        status_t want;
        if (!aresetn) begin
            win.min_period    = RST_MIN_PERIOD;
            win.max_period    = RST_MAX_PERIOD;
            win.min_high      = RST_MIN_HIGH;
            win.max_high      = RST_MAX_HIGH;
            win.loss_timeout  = RST_LOSS_TIMEOUT;
            win.pulses_needed = RST_PULSES_NEEDED;
            threshold         = RST_SWITCH_THRESH;
            prim = '{1'b0, '0, '0, RST_LOCK};
            swch = '{1'b0, '0, '0, RST_LOCK};
            last_switch_high = '0;
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_PERIOD:    win.min_period    = cfg_data;
                    REG_MAX_PERIOD:    win.max_period    = cfg_data;
                    REG_MIN_HIGH:      win.min_high      = cfg_data;
                    REG_MAX_HIGH:      win.max_high      = cfg_data;
                    REG_LOSS_TIMEOUT:  win.loss_timeout  = cfg_data;
                    REG_SWITCH_THRESH: threshold         = cfg_data;
                    REG_PULSES_NEEDED: win.pulses_needed = cfg_data[LOCK_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = status_t'(m_tdata[2:0]);
                if (status_due.size() == 0) begin
                    $error("status word %b with no tick pending", m_tdata);
                    fail_count++;
                end else begin
                    want = status_due.pop_front();
                    if (got.rc_drive !== want.rc_drive) begin
                        $error("rc_drive: expected %0d, got %0d", want.rc_drive, got.rc_drive);
                        fail_count++;
                    end
                    if (got.primary_present !== want.primary_present) begin
                        $error("primary_present: expected %0d, got %0d",
                               want.primary_present, got.primary_present);
                        fail_count++;
                    end
                    if (got.switch_present !== want.switch_present) begin
                        $error("switch_present: expected %0d, got %0d",
                               want.switch_present, got.switch_present);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                status_due.push_back(predict_status(s_tdata[0], s_tdata[1]));
        end
        owed = status_due.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the RC signal presence mux testbench: clock, reset, tick and config stimulus,
// receiver back-pressure and the verdict. Depends on rspm_pkg and rspm_status_check.
module testbench;
    import rspm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam logic [IDX_BITS-1:0] REG_SPARE = 3'd7;

    typedef struct {
        int min_period;
        int max_period;
        int min_high;
        int max_high;
        int loss_timeout;
        int switch_threshold;
        int pulses_needed;
    } tick_cfg_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data  = '0;

    int        mismatches;
    int        owed;
    int        quiet;
    bit        idling = 1'b1;
    int        hold_asks = 0;
    tick_cfg_t cur = '{50, 500, 3, 30, 600, 15, 3};
    bit        gen_lvl[2];
    int        gen_left[2];
    int        gen_high[2];

    rc_signal_presence_mux u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rspm_status_check u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(mismatches), .owed(owed)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: random stalls while idling is set, plus a long hold each time one is asked for.
    initial begin : sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idling && $urandom_range(99) < 6);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_tick(input bit p_level, input bit s_level);
        while (idling && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, s_level, p_level};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stop offering ticks until every status word is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (owed != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [IDX_BITS-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_BITS-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic load_config(input tick_cfg_t c);
        drain();
        cfg_write(REG_MIN_PERIOD, c.min_period);
        cfg_write(REG_MAX_PERIOD, c.max_period);
        cfg_write(REG_MIN_HIGH, c.min_high);
        cfg_write(REG_MAX_HIGH, c.max_high);
        cfg_write(REG_LOSS_TIMEOUT, c.loss_timeout);
        cfg_write(REG_SWITCH_THRESH, c.switch_threshold);
        cfg_write(REG_PULSES_NEEDED, c.pulses_needed);
        cfg_write(REG_SPARE, $urandom);   // unmapped index, must be dropped
        cfg_valid <= 1'b0;
        @(negedge aclk);
        cur = c;
    endtask

    function automatic tick_cfg_t random_cfg();
        tick_cfg_t c;
        c.min_high         = $urandom_range(4, 0);
        c.max_high         = c.min_high + $urandom_range(10, 2);
        c.min_period       = $urandom_range(10, 2);
        c.max_period       = c.min_period + $urandom_range(20, 4);
        c.loss_timeout     = $urandom_range(30, 6);
        c.switch_threshold = $urandom_range(12, 0);
        c.pulses_needed    = $urandom_range(7, 1);
        return c;
    endfunction

    function automatic int span(int a, int b);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (hi > 40) hi = 40;
        if (hi < 1)  hi = 1;
        if (lo < 1)  lo = 1;
        if (lo > hi) lo = hi;
        return $urandom_range(hi, lo);
    endfunction

    // Length of the next high or low stretch: mostly inside the windows,
    // sometimes a loss-length low, sometimes anything.
    function automatic int next_len(int ch, bit high);
        int r;
        r = $urandom_range(99);
        if (high) begin
            if (r < 80)
                return span(cur.min_high + 1, cur.max_high - 1);
            return span(1, cur.max_high + 2);
        end
        if (r < 70)
            return span(cur.min_period + 1 - gen_high[ch], cur.max_period - 1 - gen_high[ch]);
        if (r < 85)
            return span(cur.loss_timeout + 1, cur.loss_timeout + 3);
        return span(1, cur.max_period + 2);
    endfunction

    task automatic advance_gen(input int ch);
        gen_left[ch]--;
        if (gen_left[ch] <= 0) begin
            gen_lvl[ch]  = !gen_lvl[ch];
            gen_left[ch] = next_len(ch, gen_lvl[ch]);
            if (gen_lvl[ch])
                gen_high[ch] = gen_left[ch];
        end
    endtask

    task automatic run_random(input int n);
        bit p_level;
        bit s_level;
        repeat (n) begin
            p_level = gen_lvl[0];
            s_level = gen_lvl[1];
            // occasional glitch on top of the pulse train
            if ($urandom_range(99) < 4) p_level = !p_level;
            if ($urandom_range(99) < 4) s_level = !s_level;
            send_tick(p_level, s_level);
            advance_gen(0);
            advance_gen(1);
        end
    endtask

    initial begin : stimulus
        int        i;
        gen_lvl  = '{1'b0, 1'b0};
        gen_left = '{1, 1};
        gen_high = '{1, 1};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset windows, every level combination
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        // clean pulse trains on both channels, not enough to lock them
        load_config('{4, 20, 1, 8, 12, 3, 2});
        for (i = 0; i < 20; i++)
            send_tick((i % 9) < 2, (i % 9) < 5);

        idling = 1'b0;
        run_random(60);
        hold_asks++;
        run_random(70);
        idling = 1'b1;

        load_config(random_cfg());
        run_random(60);
        drain();
        run_random(70);

        // widest windows, loss on every low tick, zero pulses via masked data
        load_config('{0, 65535, 0, 65535, 0, 0, 16'hFFF8});
        run_random(30);
        // nothing can be valid
        load_config('{65535, 0, 65535, 0, 1, 65535, 7});
        run_random(30);

        load_config(random_cfg());
        run_random(100);

        drain();
        repeat (10) @(negedge aclk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/rspm_pkg.sv
sv/rspm_chan.sv
sv/rc_signal_presence_mux.sv
sim/rspm_status_check.sv
sim/testbench.sv
